[sv/ctcs_pkg.sv]
// Shared types and constants for the character terminal cell store.
// No dependencies; compile before every other file of the block.
`default_nettype none

package ctcs_pkg;

   // Operation codes carried by a request transfer
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_BLINK = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // Character codes
   localparam logic [6:0] CODE_MARKER     = 7'h00;
   localparam logic [6:0] CODE_CR         = 7'h0D;
   localparam logic [6:0] CODE_SPACE      = 7'h20;
   localparam logic [6:0] CODE_AT         = 7'h40;
   localparam logic [6:0] CODE_LOWER_A    = 7'h61;
   localparam logic [6:0] CODE_LOWER_Z    = 7'h7A;
   localparam logic [6:0] CODE_LAST_PRINT = 7'h7E;
   localparam logic [6:0] CASE_OFFSET     = 7'd32;

   // Strobes from the controller to the datapath, one per controller step
   typedef struct packed {
      logic load;     // capture the request payload
      logic decode;   // act on the operation, pick the physical row
      logic rowadr;   // form the row base address
      logic fill;     // write one space of a fresh row
      logic put;      // store the glyph and advance the cursor
      logic rdmem;    // read the cell memory
      logic rdval;    // take the read data as the cell value
      logic respond;  // load the response register
   } ctcs_cmd_type;

   // Status from the datapath back to the controller
   typedef struct packed {
      logic [1:0] op;
      logic       is_cr;
      logic       is_print;
      logic       read_mem;   // the read needs the cell memory
      logic       row_valid;  // the selected physical row holds data
      logic       fill_last;  // the fill sweep is at its last column
   } ctcs_status_type;

endpackage

`default_nettype wire

[sv/ctcs_req_if.sv]
// Request channel of the character terminal cell store: valid/ready plus payload.
// Depends on nothing.
`default_nettype none

interface ctcs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] char_code;
   logic [4:0] read_row;
   logic [5:0] read_col;

   modport source (output valid, output opcode, output char_code, output read_row,
                   output read_col, input ready);
   modport sink   (input valid, input opcode, input char_code, input read_row,
                   input read_col, output ready);
endinterface

`default_nettype wire

[sv/ctcs_rsp_if.sv]
// Response channel of the character terminal cell store: valid/ready plus payload.
// Depends on nothing.
`default_nettype none

interface ctcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] cell_value;
   logic [5:0] cursor_column;
   logic [4:0] cursor_line;
   logic       did_scroll;

   modport source (output valid, output cell_value, output cursor_column,
                   output cursor_line, output did_scroll, input ready);
   modport sink   (input valid, input cell_value, input cursor_column,
                   input cursor_line, input did_scroll, output ready);
endinterface

`default_nettype wire

[sv/ctcs_ctrl.sv]
// Controller state machine of the character terminal cell store.
// Depends on ctcs_pkg (command and status types, operation codes).
`default_nettype none

module ctcs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  ctcs_pkg::ctcs_status_type status_i,
   output ctcs_pkg::ctcs_cmd_type    cmd_o
);
   import ctcs_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_ROWADR = 3'd2;
   localparam logic [2:0] S_FILL   = 3'd3;
   localparam logic [2:0] S_PUT    = 3'd4;
   localparam logic [2:0] S_RDMEM  = 3'd5;
   localparam logic [2:0] S_RDVAL  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd_o         = '0;
      cmd_o.load    = (state_ff == S_IDLE) && req_valid;
      cmd_o.decode  = (state_ff == S_DECODE);
      cmd_o.rowadr  = (state_ff == S_ROWADR);
      cmd_o.fill    = (state_ff == S_FILL);
      cmd_o.put     = (state_ff == S_PUT);
      cmd_o.rdmem   = (state_ff == S_RDMEM);
      cmd_o.rdval   = (state_ff == S_RDVAL);
      cmd_o.respond = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if ((status_i.op == OP_WRITE && status_i.is_print) ||
                (status_i.op == OP_READ && status_i.read_mem))
               state_in = S_ROWADR;
            else
               state_in = S_DONE;
         end
         S_ROWADR: begin
            if (status_i.op == OP_READ) state_in = S_RDMEM;
            else if (status_i.row_valid) state_in = S_PUT;
            else state_in = S_FILL;
         end
         S_FILL: begin
            if (status_i.fill_last) state_in = S_PUT;
         end
         S_PUT:   state_in = S_DONE;
         S_RDMEM: state_in = S_RDVAL;
         S_RDVAL: state_in = S_DONE;
         S_DONE: begin
            if (cmd_o.respond) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd_o.respond) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_cmd_single: assert property (@(posedge clock) disable iff (reset) $onehot0(cmd_o))
      else $error("more than one datapath command at once");
   a_fill_fresh_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> !status_i.row_valid)
      else $error("fill sweep over a row that already holds data");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("response dropped before its transfer");

endmodule

`default_nettype wire

[sv/ctcs_dpath.sv]
// Datapath of the character terminal cell store: cursor, row rotation, row valid
// bits, blink phase, cell memory and response registers. Depends on ctcs_pkg.
`default_nettype none

module ctcs_dpath #(
   parameter int COLUMNS = 40,
   parameter int ROWS    = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctcs_pkg::ctcs_cmd_type    cmd_i,
   output ctcs_pkg::ctcs_status_type status_o,
   input  logic [1:0]                req_opcode,
   input  logic [7:0]                req_char_code,
   input  logic [4:0]                req_read_row,
   input  logic [5:0]                req_read_col,
   output logic [6:0]                rsp_cell_value,
   output logic [5:0]                rsp_cursor_column,
   output logic [4:0]                rsp_cursor_line,
   output logic                      rsp_did_scroll
);
   import ctcs_pkg::*;

   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [RW:0]   ROWS_W   = (RW + 1)'(ROWS);
   localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
   localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
   localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);

   // Captured request
   logic [1:0] op_ff;
   logic [6:0] char_ff;
   logic [4:0] rrow_ff;
   logic [5:0] rcol_ff;

   // Control state
   logic [CW-1:0]   cur_col_ff, cur_col_in;
   logic [RW-1:0]   cur_row_ff, cur_row_in;
   logic [RW-1:0]   base_ff, base_in;
   logic [ROWS-1:0] valid_ff, valid_in;
   logic            blink_ff, blink_in;
   logic            scroll_ff, scroll_in;

   // Working registers
   logic [RW-1:0] prow_ff;
   logic [AW-1:0] rbase_ff;
   logic [CW-1:0] fill_ff;
   logic [6:0]    val_ff;
   logic [6:0]    rdata_ff;
   logic [6:0]    mem [DEPTH];

   logic          is_cr, is_print, rd_in_range, rd_at_cursor, row_valid_now, col_at_end;
   logic          newline_go;
   logic [RW-1:0] lrow, phys;
   logic [RW:0]   psum;
   logic [6:0]    glyph, marker_shown;
   logic [RW-1:0] base_next;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [6:0]    mem_wdata;

   assign is_cr    = (char_ff == CODE_CR);
   assign is_print = (char_ff >= CODE_SPACE) && (char_ff <= CODE_LAST_PRINT);
   assign glyph    = (char_ff >= CODE_LOWER_A && char_ff <= CODE_LOWER_Z) ?
                     char_ff - CASE_OFFSET : char_ff;
   assign marker_shown = blink_ff ? CODE_AT : CODE_SPACE;

   assign rd_in_range  = (int'(rrow_ff) < ROWS) && (int'(rcol_ff) < COLUMNS);
   assign rd_at_cursor = (int'(rrow_ff) == int'(cur_row_ff)) &&
                         (int'(rcol_ff) == int'(cur_col_ff));

   // Logical to physical row through the rotating base
   assign lrow = (op_ff == OP_READ) ? RW'(rrow_ff) : cur_row_ff;
   always_comb begin
      psum = {1'b0, base_ff} + {1'b0, lrow};
      if (psum >= ROWS_W) psum = psum - ROWS_W;
      phys = psum[RW-1:0];
   end
   assign row_valid_now = valid_ff[phys];

   assign col_at_end = (cur_col_ff == COL_LAST);
   assign base_next  = (base_ff == ROW_LAST) ? '0 : base_ff + RW'(1);
   assign newline_go = (cmd_i.decode && op_ff == OP_WRITE && is_cr) ||
                       (cmd_i.put && col_at_end);

   always_comb begin
      status_o           = '0;
      status_o.op        = op_ff;
      status_o.is_cr     = is_cr;
      status_o.is_print  = is_print;
      status_o.read_mem  = rd_in_range && !rd_at_cursor && row_valid_now;
      status_o.row_valid = valid_ff[prow_ff];
      status_o.fill_last = (fill_ff == COL_LAST);
   end

   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      base_in    = base_ff;
      valid_in   = valid_ff;
      blink_in   = blink_ff;
      scroll_in  = scroll_ff;
      if (cmd_i.decode) begin
         scroll_in = 1'b0;
         if (op_ff == OP_BLINK) blink_in = ~blink_ff;
         if (op_ff == OP_CLEAR) begin
            cur_col_in = '0;
            cur_row_in = '0;
            base_in    = '0;
            valid_in   = '0;
         end
      end
      if (cmd_i.put && !col_at_end) cur_col_in = cur_col_ff + CW'(1);
      if (cmd_i.fill && status_o.fill_last) valid_in[prow_ff] = 1'b1;
      if (newline_go) begin
         cur_col_in = '0;
         if (cur_row_ff == ROW_LAST) begin
            // top physical row becomes the blank bottom row
            base_in           = base_next;
            valid_in[base_ff] = 1'b0;
            scroll_in         = 1'b1;
         end else begin
            cur_row_in = cur_row_ff + RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         base_ff    <= '0;
         valid_ff   <= '0;
         blink_ff   <= 1'b0;
         scroll_ff  <= 1'b0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         base_ff    <= base_in;
         valid_ff   <= valid_in;
         blink_ff   <= blink_in;
         scroll_ff  <= scroll_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         op_ff   <= req_opcode;
         char_ff <= req_char_code[6:0];
         rrow_ff <= req_read_row;
         rcol_ff <= req_read_col;
      end
      if (cmd_i.decode) begin
         prow_ff <= phys;
         val_ff  <= '0;
         if (op_ff == OP_READ && rd_in_range) begin
            if (rd_at_cursor) val_ff <= marker_shown;
            else if (!row_valid_now) val_ff <= CODE_SPACE;
         end
      end
      if (cmd_i.rowadr) begin
         rbase_ff <= AW'(prow_ff) * COLS_A;
         fill_ff  <= '0;
      end
      if (cmd_i.fill) fill_ff <= fill_ff + CW'(1);
      if (cmd_i.rdval) val_ff <= (rdata_ff == CODE_MARKER) ? marker_shown : rdata_ff;
      if (cmd_i.respond) begin
         rsp_cell_value    <= val_ff;
         rsp_cursor_column <= 6'(cur_col_ff);
         rsp_cursor_line   <= 5'(cur_row_ff);
         rsp_did_scroll    <= scroll_ff;
      end
   end

   // Cell memory: one write port, one registered read port
   assign mem_we    = cmd_i.fill || cmd_i.put;
   assign mem_waddr = rbase_ff + AW'(cmd_i.fill ? fill_ff : cur_col_ff);
   assign mem_wdata = cmd_i.fill ? CODE_SPACE : glyph;
   assign mem_raddr = rbase_ff + AW'(rcol_ff);

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd_i.rdmem) rdata_ff <= mem[mem_raddr];
   end

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (int'(cur_col_ff) < COLUMNS) && (int'(cur_row_ff) < ROWS))
      else $error("cursor outside the screen");
   a_scroll_bottom: assert property (@(posedge clock) disable iff (reset)
      scroll_ff |-> (cur_row_ff == ROW_LAST))
      else $error("scroll flagged with cursor off the bottom row");
   a_put_valid_row: assert property (@(posedge clock) disable iff (reset)
      cmd_i.put |-> valid_ff[prow_ff])
      else $error("glyph stored into a row that was never filled");

endmodule

`default_nettype wire

[sv/character_terminal_cell_store.sv]
// Character terminal cell store: a ROWS x COLUMNS text screen with cursor,
// line wrap, scroll, blink marker, clear and cell read-back.
// One request transfer on req_ch (valid/ready) gives exactly one response
// transfer on rsp_ch, in order. The response carries the displayed cell value
// for a read (0 for other operations), the cursor after the item and a scroll flag.
// Controller steps from the accepting edge to the respond step:
//    decode  blink, clear, carriage return, ignored controls, reads that
//              hit the cursor, an empty row or a cell out of range
//    decode, rowadr, put  printable character into a row that already holds data
//    decode, rowadr, rdmem, rdval  read of a stored cell (one registered memory read)
//    decode, rowadr, fill, put  printable character into a fresh row; the single
//              memory write port sweeps the row with spaces first
// One item is at work at a time; a new request is taken in the cycle after the
// previous response is loaded, even while that response is still stalled.
// Scroll and clear take no sweep: rows rotate through a base pointer and
// each physical row carries a valid bit, so a row not yet written reads as
// spaces. Reset clears the cursor, the blink phase and every row valid bit,
// leaving a blank screen with the marker at the top-left cell.
// A stalled receiver holds the response register; an item that finishes
// meanwhile waits in the controller until the register frees.
`default_nettype none

module character_terminal_cell_store #(
   parameter int COLUMNS = 40,
   parameter int ROWS    = 20
) (
   input  logic         clock,
   input  logic         reset,
   ctcs_req_if.sink     req_ch,
   ctcs_rsp_if.source   rsp_ch
);
   import ctcs_pkg::*;

   ctcs_cmd_type    cmd;
   ctcs_status_type status;

   // Sequencing: accept, decode, optional row sweep, store or read, respond
   ctcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   // Screen state, cell memory and the response payload register
   ctcs_dpath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd_i             (cmd),
      .status_o          (status),
      .req_opcode        (req_ch.opcode),
      .req_char_code     (req_ch.char_code),
      .req_read_row      (req_ch.read_row),
      .req_read_col      (req_ch.read_col),
      .rsp_cell_value    (rsp_ch.cell_value),
      .rsp_cursor_column (rsp_ch.cursor_column),
      .rsp_cursor_line   (rsp_ch.cursor_line),
      .rsp_did_scroll    (rsp_ch.did_scroll)
   );

endmodule

`default_nettype wire

[tb/sv/ctcs_screen_checker.sv]
// Checker for the character terminal cell store: keeps a shadow copy of the screen,
// predicts one response per request transfer and compares it with the response channel.
// Depends on ctcs_pkg, ctcs_req_if and ctcs_rsp_if.
`default_nettype none

module ctcs_screen_checker #(
   parameter int COLUMNS = 40,
   parameter int ROWS    = 20
) (
   input  logic clock,
   input  logic reset,
   ctcs_req_if  req_ch,
   ctcs_rsp_if  rsp_ch,
   output int   fail_count,
   output int   outstanding,
   output int   checked_count,
   output int   scroll_count
);
   import ctcs_pkg::*;

   typedef struct packed {
      logic [6:0] shown;
      logic [5:0] column;
      logic [4:0] line;
      logic       scrolled;
   } screen_report_type;

   logic [6:0]        glyphs [ROWS][COLUMNS];
   int unsigned       cur_col;
   int unsigned       cur_row;
   logic              blink_phase;
   screen_report_type reports_due [$];
   int                mismatches = 0;
   int                checked    = 0;
   int                scrolls    = 0;

   function void blank_screen();
      for (int r = 0; r < ROWS; r++)
         for (int c = 0; c < COLUMNS; c++)
            glyphs[r][c] = CODE_SPACE;
      cur_col = 0;
      cur_row = 0;
      glyphs[0][0] = CODE_MARKER;
   endfunction

   // Start of the next line; shift the rows up when the bottom is passed.
   function logic break_line();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
         for (int r = 0; r + 1 < ROWS; r++)
            for (int c = 0; c < COLUMNS; c++)
               glyphs[r][c] = glyphs[r + 1][c];
         for (int c = 0; c < COLUMNS; c++)
            glyphs[ROWS - 1][c] = CODE_SPACE;
         cur_row = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function screen_report_type advance_screen(logic [1:0] op, logic [7:0] raw,
                                              logic [4:0] rr, logic [5:0] rc);
      logic [6:0]        ch;
      logic [6:0]        shown;
      logic              scrolled;
      screen_report_type rep;
      ch       = raw[6:0];
      shown    = '0;
      scrolled = 1'b0;
      case (op)
         OP_WRITE: begin
            if (ch == CODE_CR) begin
               glyphs[cur_row][cur_col] = CODE_SPACE;
               scrolled = break_line();
               glyphs[cur_row][cur_col] = CODE_MARKER;
            end else if (ch >= CODE_SPACE && ch <= CODE_LAST_PRINT) begin
               if (ch >= CODE_LOWER_A && ch <= CODE_LOWER_Z)
                  ch = ch - CASE_OFFSET;
               glyphs[cur_row][cur_col] = ch;
               cur_col++;
               if (cur_col >= COLUMNS)
                  scrolled = break_line();
               glyphs[cur_row][cur_col] = CODE_MARKER;
            end
         end
         OP_READ: begin
            if (rr < ROWS && rc < COLUMNS) begin
               shown = glyphs[rr][rc];
               if (shown == CODE_MARKER)
                  shown = blink_phase ? CODE_AT : CODE_SPACE;
            end
         end
         OP_BLINK: blink_phase = ~blink_phase;
         OP_CLEAR: blank_screen();
         default: ;
      endcase
      rep.shown    = shown;
      rep.column   = 6'(cur_col);
      rep.line     = 5'(cur_row);
      rep.scrolled = scrolled;
      return rep;
   endfunction

   function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      screen_report_type want;
      if (reset) begin
         blank_screen();
         blink_phase = 1'b0;
         reports_due.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (reports_due.size() == 0) begin
               $display("%0t: response transfer, expected none, actual value %0d at %0d,%0d",
                        $time, rsp_ch.cell_value, rsp_ch.cursor_line, rsp_ch.cursor_column);
               mismatches++;
            end else begin
               want = reports_due.pop_front();
               compare_field("cell_value", 8'(want.shown), 8'(rsp_ch.cell_value));
               compare_field("cursor_column", 8'(want.column), 8'(rsp_ch.cursor_column));
               compare_field("cursor_line", 8'(want.line), 8'(rsp_ch.cursor_line));
               compare_field("did_scroll", 8'(want.scrolled), 8'(rsp_ch.did_scroll));
               checked++;
               if (want.scrolled)
                  scrolls++;
            end
         end
         if (req_ch.valid && req_ch.ready)
            reports_due.push_back(advance_screen(req_ch.opcode, req_ch.char_code,
                                                 req_ch.read_row, req_ch.read_col));
      end
      fail_count    <= mismatches;
      outstanding   <= reports_due.size();
      checked_count <= checked;
      scroll_count  <= scrolls;
   end

endmodule

`default_nettype wire

[tb/sv/tb_character_terminal_cell_store.sv]
// Top of the character terminal cell store testbench: clock, reset, request and
// response traffic with random idling, and the verdict. Depends on ctcs_pkg, both
// channel interfaces, the block itself and ctcs_screen_checker.
`default_nettype none

module tb_character_terminal_cell_store;
   import ctcs_pkg::*;

   localparam int COLUMNS      = 40;
   localparam int ROWS         = 20;
   localparam int ITEM_TARGET  = 500;
   // Slowest item: the longest request gap, a fresh-row fill and the longest
   // response stall; the limit lies far above that.
   localparam int CYCLE_LIMIT  = 400000;
   // Drain time after the end, with room to spare over the longest item, a fresh-row fill.
   localparam int DRAIN_CYCLES = 2 * (COLUMNS + 5);

   // Control codes the block must ignore
   localparam logic [6:0] CODE_LF     = 7'h0A;
   localparam logic [6:0] CODE_RUBOUT = 7'h7F;

   logic clock;
   logic reset;

   ctcs_req_if req_ch ();
   ctcs_rsp_if rsp_ch ();

   int fail_count;
   int outstanding;
   int checked_count;
   int scroll_count;

   // Idle bounds, changed per burst so that some stretches run with no gaps
   int req_gap_max   = 6;
   int rsp_stall_max = 6;

   int sent_count    = 0;
   int ignored_count = 0;
   int cycle_count   = 0;

   // Cursor as last reported by the block, used to aim reads at the marker
   logic [5:0] seen_col  = '0;
   logic [4:0] seen_line = '0;

   character_terminal_cell_store #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ctcs_screen_checker #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) screen_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count),
      .scroll_count  (scroll_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Watchdog: give up well past the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding",
                  cycle_count, outstanding);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Response side: hold ready low for a random stall before each transfer,
   // then keep it high until the transfer happens. Note the reported cursor.
   initial begin
      int stall;
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do
            @(posedge clock);
         while (!rsp_ch.valid);
         seen_col  = rsp_ch.cursor_column;
         seen_line = rsp_ch.cursor_line;
      end
   end

   // Offer one request after a random gap and hold it until the transfer.
   // Drop valid only when a gap follows, so it never toggles within one step.
   task automatic send(input logic [1:0] op, input logic [7:0] code,
                       input logic [4:0] row, input logic [5:0] col);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.opcode    <= op;
      req_ch.char_code <= code;
      req_ch.read_row  <= row;
      req_ch.read_col  <= col;
      do
         @(posedge clock);
      while (!req_ch.ready);
      sent_count++;
   endtask

   // Unused fields carry random bits so that every input bit toggles.
   task automatic send_write(input logic [7:0] code);
      send(OP_WRITE, code, 5'($urandom), 6'($urandom));
   endtask

   task automatic send_read(input logic [4:0] row, input logic [5:0] col);
      send(OP_READ, 8'($urandom), row, col);
   endtask

   task automatic send_plain(input logic [1:0] op);
      send(op, 8'($urandom), 5'($urandom), 6'($urandom));
   endtask

   function automatic logic [7:0] random_printable();
      return {1'($urandom_range(0, 1)), 7'($urandom_range(32, 126))};
   endfunction

   // A control code other than carriage return, top bit at random
   function automatic logic [7:0] random_control();
      logic [6:0] code;
      code = 7'($urandom_range(0, 32));
      if (code == 7'd32 || code == CODE_CR)
         code = CODE_RUBOUT;
      return {1'($urandom_range(0, 1)), code};
   endfunction

   initial begin
      int kind;
      int len;
      int pick;
      req_ch.valid     <= 1'b0;
      req_ch.opcode    <= OP_WRITE;
      req_ch.char_code <= '0;
      req_ch.read_row  <= '0;
      req_ch.read_col  <= '0;
      reset            <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The marker at the top-left reads as a space, then as
      // '@' once the blink phase has toggled.
      send_read(5'd0, 6'd0);
      send_plain(OP_BLINK);
      send_read(5'd0, 6'd0);
      // Lower case folds, bit 7 drops, underscore and the printable edges store.
      send_write({1'b0, CODE_LOWER_A});
      send_write({1'b1, CODE_LOWER_Z});
      send_write(8'h5F);
      send_write({1'b0, CODE_LAST_PRINT});
      send_write({1'b0, CODE_SPACE});
      send_write(8'h60);
      send_write(8'h7B);
      // Line feed, rubout and other controls change nothing.
      send_write({1'b0, CODE_LF});
      send_write({1'b1, CODE_RUBOUT});
      send_write({1'b0, CODE_MARKER});
      send_write(8'h1F);
      send_read(5'd0, 6'd0);
      send_read(5'd0, 6'd7);
      // Carriage return with bit 7 set blanks the old marker cell.
      send_write({1'b1, CODE_CR});
      send_read(5'd0, 6'd7);
      // Reads off the screen return zero; the far corner is in range.
      send_read(5'd31, 6'd63);
      send_read(5'(ROWS), 6'd0);
      send_read(5'd0, 6'(COLUMNS));
      send_read(5'(ROWS - 1), 6'(COLUMNS - 1));
      send_plain(OP_BLINK);
      send_plain(OP_CLEAR);
      send_read(5'd0, 6'd0);

      // Random part, in bursts shaped like terminal traffic: lines of text,
      // runs of carriage returns to reach the bottom and scroll, read-back,
      // ignored controls, the odd blink toggle or clear, and raw noise.
      while (sent_count - ignored_count < ITEM_TARGET) begin
         if ($urandom_range(0, 4) == 0) begin
            req_gap_max   = 0;
            rsp_stall_max = 0;
         end else begin
            req_gap_max   = 6;
            rsp_stall_max = 6;
         end
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            // Text line, long enough at times to wrap past the right edge
            len = $urandom_range(0, 60);
            repeat (len) send_write(random_printable());
            if ($urandom_range(0, 9) < 7)
               send_write({1'($urandom_range(0, 1)), CODE_CR});
         end else if (kind < 55) begin
            len = $urandom_range(1, 25);
            repeat (len) send_write({1'($urandom_range(0, 1)), CODE_CR});
         end else if (kind < 80) begin
            len = $urandom_range(1, 8);
            repeat (len) begin
               pick = $urandom_range(0, 99);
               if (pick < 25)
                  send_read(seen_line, seen_col);
               else if (pick < 85)
                  send_read(5'($urandom_range(0, ROWS - 1)),
                            6'($urandom_range(0, COLUMNS - 1)));
               else
                  send_read(5'($urandom), 6'($urandom));
            end
         end else if (kind < 88) begin
            len = $urandom_range(1, 6);
            repeat (len) send(2'($urandom), 8'($urandom), 5'($urandom), 6'($urandom));
         end else if (kind < 96) begin
            // Ignored controls do not count towards the target
            len = $urandom_range(1, 4);
            repeat (len) send_write(random_control());
            ignored_count += len;
         end else if (kind < 99) begin
            send_plain(OP_BLINK);
         end else begin
            send_plain(OP_CLEAR);
         end
      end
      req_ch.valid <= 1'b0;

      // Wait for every predicted response, then let the block settle.
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d ignored controls) on a %0dx%0d screen:",
               sent_count, ignored_count, ROWS, COLUMNS);
      $display("%0d responses checked, %0d of them scrolled the screen",
               checked_count, scroll_count);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
sv/ctcs_pkg.sv
sv/ctcs_req_if.sv
sv/ctcs_rsp_if.sv
sv/ctcs_ctrl.sv
sv/ctcs_dpath.sv
sv/character_terminal_cell_store.sv
tb/sv/ctcs_screen_checker.sv
tb/sv/tb_character_terminal_cell_store.sv
